// ===== src/amd_pkg.sv =====
// Shared constants, types and the arctangent table for the affine matrix decomposer.
`timescale 1ns / 1ps
package amd_pkg;

   localparam int CoefWidth          = 32;
   localparam int RotWidth           = 16;
   localparam int AngleWidth         = 32;
   localparam int CordicStepsDefault = 16;
   // x/y path: 33-bit magnitudes grow by the CORDIC gain and a sign bit
   localparam int CordicWidth        = CoefWidth + 3;
   localparam int SquareWidth        = 2 * CoefWidth;
   // radicand is a*a + b*b scaled by 2^14 so the root is 128*sqrt()
   localparam int RadShift           = 14;
   localparam int RadWidth           = SquareWidth + RadShift;
   localparam int LenWidth           = RadWidth / 2;
   localparam int LenLoWidth         = 20;
   // ratio numerators at or above 2^25 always saturate
   localparam int NumWidth           = 25;
   localparam int ZeroColShift       = 6;

   localparam logic [CoefWidth-1:0]  OneQ16 = 32'h0001_0000;
   localparam logic [CoefWidth-1:0]  MaxPos = 32'h7fff_ffff;
   localparam logic [CoefWidth-1:0]  MinNeg = 32'h8000_0000;
   localparam logic [AngleWidth-1:0] HalfTurn = 32'h8000_0000;
   localparam logic [AngleWidth-1:0] RotRound = 32'h0000_8000;

   typedef struct packed {
      logic [CoefWidth-1:0] mag_a;
      logic [CoefWidth-1:0] mag_b;
      logic [CoefWidth-1:0] mag_c;
      logic [CoefWidth-1:0] mag_d;
      logic                 neg_a;
      logic                 neg_b;
      logic                 neg_c;
      logic                 neg_d;
      logic [CoefWidth-1:0] pos_x;
      logic [CoefWidth-1:0] pos_y;
   } coef_type;

   typedef struct packed {
      logic [RotWidth-1:0]  rot;
      logic                 fell;
      logic                 zero_col;
      logic                 neg_q;
      logic [CoefWidth-1:0] num;
      logic [CoefWidth-1:0] den;
      logic [CoefWidth-1:0] mag_d;
      logic [CoefWidth-1:0] pos_x;
      logic [CoefWidth-1:0] pos_y;
   } mid_type;

   typedef struct packed {
      logic [RotWidth-1:0]  rot;
      logic                 fell;
      logic                 zero_col;
      logic                 neg_q;
      logic                 big;
      logic [CoefWidth-1:0] mag_d;
      logic [LenWidth-1:0]  len;
      logic [CoefWidth-1:0] pos_x;
      logic [CoefWidth-1:0] pos_y;
   } tail_type;

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic [AngleWidth-1:0] atan_turn(input logic [4:0] idx);
      logic [AngleWidth-1:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== src/amd_cordic.sv =====
// Pipelined CORDIC vectoring unit, one rotation step per stage.
`timescale 1ns / 1ps
module amd_cordic #(
   parameter int STEPS = 16,
   parameter int TAG_W = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic signed [amd_pkg::CordicWidth-1:0]    in_x,
   input  logic signed [amd_pkg::CordicWidth-1:0]    in_y,
   input  logic        [amd_pkg::AngleWidth-1:0]     in_acc,
   input  logic        [TAG_W-1:0]                   in_tag,
   output logic                                      out_valid,
   output logic        [amd_pkg::AngleWidth-1:0]     out_acc,
   output logic        [TAG_W-1:0]                   out_tag
);
   import amd_pkg::*;

   logic [STEPS-1:0]               valid_ff;
   logic signed [CordicWidth-1:0]  x_ff   [STEPS];
   logic signed [CordicWidth-1:0]  y_ff   [STEPS];
   logic [AngleWidth-1:0]          acc_ff [STEPS];
   logic [TAG_W-1:0]               tag_ff [STEPS];

   logic [STEPS-1:0]               valid_src;
   logic signed [CordicWidth-1:0]  x_src  [STEPS];
   logic signed [CordicWidth-1:0]  y_src  [STEPS];
   logic [AngleWidth-1:0]          acc_src[STEPS];
   logic [TAG_W-1:0]               tag_src[STEPS];
   logic signed [CordicWidth-1:0]  x_in   [STEPS];
   logic signed [CordicWidth-1:0]  y_in   [STEPS];
   logic [AngleWidth-1:0]          acc_in [STEPS];

   always_comb begin
      valid_src[0] = in_valid;
      x_src[0]     = in_x;
      y_src[0]     = in_y;
      acc_src[0]   = in_acc;
      tag_src[0]   = in_tag;
      for (int k = 1; k < STEPS; k++) begin
         valid_src[k] = valid_ff[k-1];
         x_src[k]     = x_ff[k-1];
         y_src[k]     = y_ff[k-1];
         acc_src[k]   = acc_ff[k-1];
         tag_src[k]   = tag_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         // y above zero: turn clockwise
         if (y_src[k] > 0) begin
            x_in[k]   = x_src[k] + (y_src[k] >>> k);
            y_in[k]   = y_src[k] - (x_src[k] >>> k);
            acc_in[k] = acc_src[k] + atan_turn(5'(k));
         end else begin
            x_in[k]   = x_src[k] - (y_src[k] >>> k);
            y_in[k]   = y_src[k] + (x_src[k] >>> k);
            acc_in[k] = acc_src[k] - atan_turn(5'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_src;
      end
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            acc_ff[k] <= acc_in[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_acc   = acc_ff[STEPS-1];
   assign out_tag   = tag_ff[STEPS-1];

endmodule

// ===== src/amd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module amd_sqrt #(
   parameter int RAD_W = 78,
   parameter int TAG_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [RAD_W-1:0]       in_rad,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output logic [RAD_W/2-1:0]     out_root,
   output logic [TAG_W-1:0]       out_tag
);
   localparam int QW  = RAD_W / 2;
   localparam int RMW = QW + 2;
   localparam int CW  = QW + 4;

   logic [QW-1:0]     valid_ff;
   logic [RAD_W-1:0]  n_ff   [QW];
   logic [RMW-1:0]    r_ff   [QW];
   logic [QW-1:0]     q_ff   [QW];
   logic [TAG_W-1:0]  tag_ff [QW];

   logic [QW-1:0]     valid_src;
   logic [RAD_W-1:0]  n_src  [QW];
   logic [RMW-1:0]    r_src  [QW];
   logic [QW-1:0]     q_src  [QW];
   logic [TAG_W-1:0]  tag_src[QW];
   logic [CW-1:0]     r_wide [QW];
   logic [CW-1:0]     trial  [QW];
   logic [RMW-1:0]    r_in   [QW];
   logic [QW-1:0]     q_in   [QW];

   always_comb begin
      valid_src[0] = in_valid;
      n_src[0]     = in_rad;
      r_src[0]     = '0;
      q_src[0]     = '0;
      tag_src[0]   = in_tag;
      for (int k = 1; k < QW; k++) begin
         valid_src[k] = valid_ff[k-1];
         n_src[k]     = n_ff[k-1];
         r_src[k]     = r_ff[k-1];
         q_src[k]     = q_ff[k-1];
         tag_src[k]   = tag_ff[k-1];
      end
      for (int k = 0; k < QW; k++) begin
         r_wide[k] = {r_src[k], n_src[k][RAD_W-1 -: 2]};
         trial[k]  = {2'b00, q_src[k], 2'b01};
         if (r_wide[k] >= trial[k]) begin
            r_in[k] = RMW'(r_wide[k] - trial[k]);
            q_in[k] = {q_src[k][QW-2:0], 1'b1};
         end else begin
            r_in[k] = r_wide[k][RMW-1:0];
            q_in[k] = {q_src[k][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_src;
      end
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            n_ff[k]   <= {n_src[k][RAD_W-3:0], 2'b00};
            r_ff[k]   <= r_in[k];
            q_ff[k]   <= q_in[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_root  = q_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

// ===== src/amd_div.sv =====
// Pipelined restoring divider with a quotient overflow flag, one quotient bit per stage.
`timescale 1ns / 1ps
module amd_div #(
   parameter int DIV_W = 32,
   parameter int TAG_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*DIV_W-1:0]    in_dividend,
   input  logic [DIV_W-1:0]      in_divisor,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [DIV_W-1:0]      out_quot,
   output logic                  out_ovf,
   output logic [TAG_W-1:0]      out_tag
);
   // stage 0 checks overflow, stages 1..DIV_W each settle one quotient bit
   logic [DIV_W:0]    valid_ff;
   logic [DIV_W-1:0]  r_ff   [DIV_W+1];
   logic [DIV_W-1:0]  low_ff [DIV_W+1];
   logic [DIV_W-1:0]  den_ff [DIV_W+1];
   logic [DIV_W:0]    ovf_ff;
   logic [TAG_W-1:0]  tag_ff [DIV_W+1];

   logic [DIV_W:0]    r_wide [DIV_W];
   logic [DIV_W-1:0]  ge;
   logic [DIV_W-1:0]  r_in   [DIV_W];

   always_comb begin
      for (int k = 0; k < DIV_W; k++) begin
         r_wide[k] = {r_ff[k], low_ff[k][DIV_W-1]};
         ge[k]     = r_wide[k] >= {1'b0, den_ff[k]};
         r_in[k]   = ge[k] ? DIV_W'(r_wide[k] - {1'b0, den_ff[k]})
                           : r_wide[k][DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_W-1:0], in_valid};
      end
      if (en) begin
         r_ff[0]   <= in_dividend[2*DIV_W-1:DIV_W];
         low_ff[0] <= in_dividend[DIV_W-1:0];
         den_ff[0] <= in_divisor;
         ovf_ff[0] <= in_dividend[2*DIV_W-1:DIV_W] >= in_divisor;
         tag_ff[0] <= in_tag;
         for (int k = 0; k < DIV_W; k++) begin
            r_ff[k+1]   <= r_in[k];
            low_ff[k+1] <= {low_ff[k][DIV_W-2:0], ge[k]};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_W];
   assign out_quot  = low_ff[DIV_W];
   assign out_ovf   = ovf_ff[DIV_W];
   assign out_tag   = tag_ff[DIV_W];

endmodule

// ===== src/affine_matrix_decompose.sv =====
// Affine matrix decomposer: one 2x3 fixed-point matrix in, scale/rotation/position out.
// One item is accepted per clock while req_ready is high; the block is a single
// pipeline that holds up to CORDIC_STEPS + 77 items in flight, one per stage: the CORDIC
// angle (one stage per step), two product stages, 39 square-root stages (one root bit
// each), two ratio-product stages, 33 divider stages (overflow check plus one quotient
// bit each) and the output register. The whole pipeline advances together; when the
// output register holds an item that is not taken, the pipeline and req_ready pause.
// Scales are Q16.16 and saturate, the angle is a 16-bit binary angle (32768 = pi), and
// a matrix that does not rebuild within one unit gives scale 1.0, angle 0 and fell_back.
`timescale 1ns / 1ps
module affine_matrix_decompose #(
   parameter int CORDIC_STEPS = amd_pkg::CordicStepsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_coef_a,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_coef_b,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_coef_c,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_coef_d,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_shift_x,
   input  logic signed [amd_pkg::CoefWidth-1:0]  req_shift_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [amd_pkg::CoefWidth-1:0]  rsp_scale_x,
   output logic signed [amd_pkg::CoefWidth-1:0]  rsp_scale_y,
   output logic signed [amd_pkg::RotWidth-1:0]   rsp_rot_angle,
   output logic signed [amd_pkg::CoefWidth-1:0]  rsp_pos_x,
   output logic signed [amd_pkg::CoefWidth-1:0]  rsp_pos_y,
   output logic                                  rsp_fell_back
);
   import amd_pkg::*;

   // pipeline advance: the output register is free or being emptied
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---- input prep: magnitudes, signs, negated y, CORDIC start vector
   coef_type                       coef_in;
   logic signed [CordicWidth-1:0]  cx_in, cy_in;
   logic [AngleWidth-1:0]          acc_in;

   always_comb begin
      coef_in.neg_a = req_coef_a[CoefWidth-1];
      coef_in.neg_b = req_coef_b[CoefWidth-1];
      coef_in.neg_c = req_coef_c[CoefWidth-1];
      coef_in.neg_d = req_coef_d[CoefWidth-1];
      coef_in.mag_a = coef_in.neg_a ? -req_coef_a : req_coef_a;
      coef_in.mag_b = coef_in.neg_b ? -req_coef_b : req_coef_b;
      coef_in.mag_c = coef_in.neg_c ? -req_coef_c : req_coef_c;
      coef_in.mag_d = coef_in.neg_d ? -req_coef_d : req_coef_d;
      coef_in.pos_x = req_shift_x;
      // -(-2^31) does not fit, so it pins to the largest positive value
      coef_in.pos_y = (req_shift_y == MinNeg) ? MaxPos : -req_shift_y;
      // left half-plane: turn by pi first
      if (coef_in.neg_a) begin
         cx_in  = -CordicWidth'(req_coef_a);
         cy_in  = -CordicWidth'(req_coef_b);
         acc_in = HalfTurn;
      end else begin
         cx_in  = CordicWidth'(req_coef_a);
         cy_in  = CordicWidth'(req_coef_b);
         acc_in = '0;
      end
   end

   // ---- angle
   logic                   cor_valid;
   logic [AngleWidth-1:0]  cor_acc;
   logic [$bits(coef_type)-1:0] cor_tag;

   amd_cordic #(
      .STEPS (CORDIC_STEPS),
      .TAG_W ($bits(coef_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_x      (cx_in),
      .in_y      (cy_in),
      .in_acc    (acc_in),
      .in_tag    (coef_in),
      .out_valid (cor_valid),
      .out_acc   (cor_acc),
      .out_tag   (cor_tag)
   );

   coef_type cor_coef;
   logic [AngleWidth-1:0] rot_round;
   assign cor_coef  = coef_type'(cor_tag);
   assign rot_round = cor_acc + RotRound;

   // ---- stage P1: squares and cross products
   logic                    p1_valid_ff;
   logic [SquareWidth-1:0]  aa_ff, bb_ff, ca_ff, db_ff;
   logic [RotWidth-1:0]     p1_rot_ff;
   coef_type                p1_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= cor_valid;
      end
      if (en) begin
         aa_ff      <= cor_coef.mag_a * cor_coef.mag_a;
         bb_ff      <= cor_coef.mag_b * cor_coef.mag_b;
         ca_ff      <= cor_coef.mag_c * cor_coef.mag_a;
         db_ff      <= cor_coef.mag_d * cor_coef.mag_b;
         p1_rot_ff  <= rot_round[AngleWidth-1 -: RotWidth];
         p1_coef_ff <= cor_coef;
      end
   end

   // ---- stage P2: length radicand, exact shear test, ratio operands
   logic [SquareWidth-1:0]  sq_sum, shear_sum;
   logic                    pneg, qneg, a_zero, b_zero;
   mid_type                 mid_in;

   always_comb begin
      sq_sum = aa_ff + bb_ff;
      pneg   = p1_coef_ff.neg_c ^ p1_coef_ff.neg_a;
      qneg   = p1_coef_ff.neg_d ^ p1_coef_ff.neg_b;
      a_zero = p1_coef_ff.mag_a == '0;
      b_zero = p1_coef_ff.mag_b == '0;
      // |c*a + d*b| from magnitudes
      if (ca_ff == '0 || db_ff == '0 || pneg == qneg) begin
         shear_sum = ca_ff + db_ff;
      end else if (ca_ff > db_ff) begin
         shear_sum = ca_ff - db_ff;
      end else begin
         shear_sum = db_ff - ca_ff;
      end
      mid_in.rot      = p1_rot_ff;
      mid_in.zero_col = a_zero && b_zero;
      if (a_zero && b_zero) begin
         mid_in.fell = p1_coef_ff.mag_c != '0;
      end else if (!a_zero) begin
         mid_in.fell = shear_sum >= SquareWidth'(p1_coef_ff.mag_a);
      end else begin
         mid_in.fell = p1_coef_ff.mag_d != '0;
      end
      // zero column carries the sign of d; zero cosine divides -c by b
      if (a_zero && b_zero) begin
         mid_in.neg_q = p1_coef_ff.neg_d;
      end else if (a_zero) begin
         mid_in.neg_q = p1_coef_ff.neg_c == p1_coef_ff.neg_b;
      end else begin
         mid_in.neg_q = p1_coef_ff.neg_d ^ p1_coef_ff.neg_a;
      end
      mid_in.num   = a_zero ? p1_coef_ff.mag_c : p1_coef_ff.mag_d;
      mid_in.den   = a_zero ? p1_coef_ff.mag_b : p1_coef_ff.mag_a;
      mid_in.mag_d = p1_coef_ff.mag_d;
      mid_in.pos_x = p1_coef_ff.pos_x;
      mid_in.pos_y = p1_coef_ff.pos_y;
   end

   logic                  p2_valid_ff;
   logic [RadWidth-1:0]   rad_ff;
   mid_type               p2_mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         rad_ff    <= {sq_sum, RadShift'(0)};
         p2_mid_ff <= mid_in;
      end
   end

   // ---- root = floor(128 * sqrt(a*a + b*b))
   logic                       sq_valid;
   logic [LenWidth-1:0]        sq_root;
   logic [$bits(mid_type)-1:0] sq_tag;

   amd_sqrt #(
      .RAD_W (RadWidth),
      .TAG_W ($bits(mid_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_rad    (rad_ff),
      .in_tag    (p2_mid_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ---- stage M1: rounded length and split ratio product
   mid_type               sq_mid;
   logic [LenWidth:0]     len_sum;
   tail_type              tail_in;
   assign sq_mid  = mid_type'(sq_tag);
   assign len_sum = {1'b0, sq_root} + (LenWidth+1)'(1);

   always_comb begin
      tail_in.rot      = sq_mid.rot;
      tail_in.fell     = sq_mid.fell;
      tail_in.zero_col = sq_mid.zero_col;
      tail_in.neg_q    = sq_mid.neg_q;
      tail_in.big      = |sq_mid.num[CoefWidth-1:NumWidth];
      tail_in.mag_d    = sq_mid.mag_d;
      tail_in.len      = len_sum[LenWidth:1];
      tail_in.pos_x    = sq_mid.pos_x;
      tail_in.pos_y    = sq_mid.pos_y;
   end

   logic                                   m1_valid_ff;
   logic [NumWidth+LenLoWidth-1:0]         plo_ff;
   logic [NumWidth+LenWidth-LenLoWidth-1:0] phi_ff;
   logic [CoefWidth-1:0]                   m1_den_ff;
   tail_type                               m1_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= sq_valid;
      end
      if (en) begin
         plo_ff     <= sq_mid.num[NumWidth-1:0] * tail_in.len[LenLoWidth-1:0];
         phi_ff     <= sq_mid.num[NumWidth-1:0] * tail_in.len[LenWidth-1:LenLoWidth];
         m1_den_ff  <= sq_mid.den;
         m1_tail_ff <= tail_in;
      end
   end

   // ---- stage M2: num * len + den / 2
   logic                    m2_valid_ff;
   logic [SquareWidth-1:0]  dividend_ff;
   logic [CoefWidth-1:0]    m2_den_ff;
   tail_type                m2_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (en) begin
         dividend_ff <= (SquareWidth'(phi_ff) << LenLoWidth) + SquareWidth'(plo_ff)
                      + SquareWidth'(m1_den_ff[CoefWidth-1:1]);
         m2_den_ff   <= m1_den_ff;
         m2_tail_ff  <= m1_tail_ff;
      end
   end

   // ---- ratio magnitude
   logic                        dv_valid;
   logic [CoefWidth-1:0]        dv_quot;
   logic                        dv_ovf;
   logic [$bits(tail_type)-1:0] dv_tag;

   amd_div #(
      .DIV_W (CoefWidth),
      .TAG_W ($bits(tail_type))
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (m2_valid_ff),
      .in_dividend (dividend_ff),
      .in_divisor  (m2_den_ff),
      .in_tag      (m2_tail_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_ovf     (dv_ovf),
      .out_tag     (dv_tag)
   );

   // ---- output: signs, saturation, special cases, fallback
   tail_type                           dv_tail;
   logic [CoefWidth+ZeroColShift-1:0]  zc_mag;
   logic                               q_sat;
   logic [CoefWidth-1:0]               scx_in, scy_in;
   logic [RotWidth-1:0]                rot_in;
   assign dv_tail = tail_type'(dv_tag);
   assign zc_mag  = {dv_tail.mag_d, ZeroColShift'(0)};
   assign q_sat   = dv_ovf || dv_tail.big;

   always_comb begin
      if (dv_tail.fell) begin
         scx_in = OneQ16;
         scy_in = OneQ16;
         rot_in = '0;
      end else if (dv_tail.zero_col) begin
         // zero first column: no angle, y scale is 64*d
         scx_in = '0;
         rot_in = '0;
         if (dv_tail.neg_q) begin
            scy_in = (zc_mag > (CoefWidth+ZeroColShift)'(MinNeg)) ? MinNeg
                                                                  : -zc_mag[CoefWidth-1:0];
         end else begin
            scy_in = (zc_mag > (CoefWidth+ZeroColShift)'(MaxPos)) ? MaxPos
                                                                  : zc_mag[CoefWidth-1:0];
         end
      end else begin
         scx_in = (dv_tail.len > LenWidth'(MaxPos)) ? MaxPos : dv_tail.len[CoefWidth-1:0];
         rot_in = dv_tail.rot;
         if (dv_tail.neg_q) begin
            scy_in = (q_sat || dv_quot > MinNeg) ? MinNeg : -dv_quot;
         end else begin
            scy_in = (q_sat || dv_quot > MaxPos) ? MaxPos : dv_quot;
         end
      end
   end

   logic [CoefWidth-1:0]  scx_ff, scy_ff, posx_ff, posy_ff;
   logic [RotWidth-1:0]   rot_ff;
   logic                  fell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         scx_ff  <= scx_in;
         scy_ff  <= scy_in;
         rot_ff  <= rot_in;
         posx_ff <= dv_tail.pos_x;
         posy_ff <= dv_tail.pos_y;
         fell_ff <= dv_tail.fell;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scale_x   = scx_ff;
   assign rsp_scale_y   = scy_ff;
   assign rsp_rot_angle = rot_ff;
   assign rsp_pos_x     = posx_ff;
   assign rsp_pos_y     = posy_ff;
   assign rsp_fell_back = fell_ff;

endmodule

// ===== src/amd_checker.sv =====
// Port-level checks for the affine matrix decomposer, bound to the top level.
`timescale 1ns / 1ps
module amd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [amd_pkg::CoefWidth-1:0]  rsp_scale_x,
   input logic signed [amd_pkg::CoefWidth-1:0]  rsp_scale_y,
   input logic signed [amd_pkg::RotWidth-1:0]   rsp_rot_angle,
   input logic                                  rsp_fell_back
);
   import amd_pkg::*;

   // a waiting item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a fallback item carries unit scales and no rotation
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fell_back |->
         rsp_scale_x == OneQ16 && rsp_scale_y == OneQ16 && rsp_rot_angle == '0)
      else $error("fallback item with non-default scale or angle");

   // x scale is a length and never negative
   a_scale_x_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_scale_x[CoefWidth-1])
      else $error("negative x scale");

   // input side stalls only while the output holds an untaken item
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

endmodule

bind affine_matrix_decompose amd_checker u_amd_checker (.*);

// ===== bench/tb_affine_matrix_decompose.sv =====
// Testbench for the affine matrix decomposer: directed table plus random matrices.
`timescale 1ns / 1ps
module tb_affine_matrix_decompose;
   import amd_pkg::*;

   localparam int Steps = CordicStepsDefault;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_coef_a = '0, req_coef_b = '0, req_coef_c = '0;
   logic signed [31:0] req_coef_d = '0, req_shift_x = '0, req_shift_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_scale_x, rsp_scale_y, rsp_pos_x, rsp_pos_y;
   logic signed [15:0] rsp_rot_angle;
   logic rsp_fell_back;

   typedef struct packed {
      logic [31:0] a, b, c, d, tx, ty;
   } matrix_type;

   typedef struct packed {
      logic [31:0] sx, sy;
      logic [15:0] rot;
      logic [31:0] px, py;
      logic        fell;
   } decomp_type;

   // directed row: matrix, typed-in answer where it is obvious
   typedef struct {
      matrix_type m;
      bit         fixed;
      decomp_type want;
   } row_type;

   decomp_type pending[$];
   int         errors = 0;
   bit         quiet_send = 1'b0;   // no random idling on the sender
   bit         quiet_recv = 1'b0;

   always #1 clock = ~clock;

   affine_matrix_decompose uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b),
      .req_coef_c(req_coef_c), .req_coef_d(req_coef_d),
      .req_shift_x(req_shift_x), .req_shift_y(req_shift_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_scale_x(rsp_scale_x), .rsp_scale_y(rsp_scale_y),
      .rsp_rot_angle(rsp_rot_angle), .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y), .rsp_fell_back(rsp_fell_back)
   );

   // ---------------- predictor ----------------
   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] fshift(logic signed [63:0] v, int sh);
      return v >>> sh;   // arithmetic shift is floor
   endfunction

   function automatic logic [31:0] angle_of(logic signed [63:0] x, logic signed [63:0] y);
      logic [31:0] acc;
      logic signed [63:0] sx, sy;
      acc = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = HalfTurn;
      end
      for (int k = 0; k < Steps && k < 32; k++) begin
         sx = fshift(y, k);
         sy = fshift(x, k);
         if (y > 0) begin
            x = x + sx;
            y = y - sy;
            acc = acc + atan_turn(k[4:0]);
         end else begin
            x = x - sx;
            y = y + sy;
            acc = acc - atan_turn(k[4:0]);
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r, bv;
      r = 0;
      bv = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= r + bv) begin
            v = v - (r + bv);
            r = (r >> 1) + bv;
         end else begin
            r = r >> 1;
         end
         bv = bv >> 2;
      end
      return r;
   endfunction

   // round(64*sqrt(sq)); 128-bit so the candidate test cannot overflow
   function automatic logic [63:0] column_length(logic [63:0] sq);
      logic [63:0] w, rem, fr, cand;
      logic [127:0] lhs, rhs;
      w = int_root(sq);
      rem = sq - w * w;
      fr = 0;
      for (int bv = 64; bv > 0; bv = bv >> 1) begin
         cand = fr | bv;
         lhs = 128'd256 * w * cand + cand * cand;
         rhs = 128'd16384 * rem;
         if (lhs <= rhs) fr = cand;
      end
      return (128 * w + fr + 1) >> 1;
   endfunction

   function automatic logic [63:0] scaled_ratio(logic [63:0] num, logic [63:0] den,
                                                logic [63:0] len);
      if (num >= (64'd1 << 25)) return 64'd1 << 32;
      return (num * len + den / 2) / den;
   endfunction

   function automatic logic [31:0] sat_pack(logic [63:0] m, bit neg);
      if (neg) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         return 32'(-m);
      end
      if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
      return m[31:0];
   endfunction

   function automatic decomp_type decompose(matrix_type m);
      decomp_type r;
      logic signed [63:0] a, b, c, d;
      logic [63:0] len, pm, qm, sum;
      logic [31:0] turn;
      bit fell, pn, qn;
      a = $signed(m.a); b = $signed(m.b); c = $signed(m.c); d = $signed(m.d);
      if (a == 0 && b == 0) begin
         r.rot = 0;
         r.sx = 0;
         r.sy = sat_pack(mag64(d) * 64, d < 0);
         fell = (c != 0);
      end else begin
         turn = angle_of(a, b);
         len = column_length(mag64(a) * mag64(a) + mag64(b) * mag64(b));
         turn = turn + RotRound;
         r.rot = turn[31:16];
         r.sx = sat_pack(len, 1'b0);
         if (a != 0) begin
            r.sy = sat_pack(scaled_ratio(mag64(d), mag64(a), len), (d < 0) != (a < 0));
            pm = mag64(c) * mag64(a);
            qm = mag64(d) * mag64(b);
            pn = (c < 0) != (a < 0);
            qn = (d < 0) != (b < 0);
            if (pm == 0 || qm == 0 || pn == qn) sum = pm + qm;
            else sum = pm > qm ? pm - qm : qm - pm;
            fell = sum >= mag64(a);
         end else begin
            r.sy = sat_pack(scaled_ratio(mag64(c), mag64(b), len), (c < 0) == (b < 0));
            fell = (d != 0);
         end
      end
      if (fell) begin
         r.sx = OneQ16;
         r.sy = OneQ16;
         r.rot = 0;
      end
      r.px = m.tx;
      r.py = (m.ty == MinNeg) ? MaxPos : -m.ty;
      r.fell = fell;
      return r;
   endfunction

   // ---------------- driver ----------------
   function automatic bit idle_now(bit quiet);
      return !quiet && ($urandom_range(99) < 36);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(matrix_type m, decomp_type want);
      while (idle_now(quiet_send)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_coef_a, req_coef_b, req_coef_c, req_coef_d, req_shift_x, req_shift_y} <= m;
      // accepted at a rising edge with ready high
      do @(posedge clock); while (!req_ready);
      pending.insert(pending.size(), want);
      @(negedge clock);
   endtask

   // random coefficient: mostly modest values, sometimes full range
   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(64)) - 32);
         2: return 32'($signed($urandom_range(8191)) - 4096);
         default: return 32'($signed($urandom_range(2097151)) - 1048576);
      endcase
   endfunction

   // mostly a rotation-scale matrix; else a = 0, a zero column or fully random
   function automatic matrix_type rand_matrix();
      matrix_type m;
      int unsigned kind;
      kind = $urandom_range(9);
      m.a = rand_coef(); m.b = rand_coef();
      m.tx = $urandom(); m.ty = $urandom();
      if (kind < 6) begin
         // c = -b*k, d = a*k keeps the shear small
         m.c = -m.b;
         m.d = m.a;
         if ($urandom_range(1)) begin m.c = -$signed(m.c) * 2; m.c = -m.c; m.d = m.a * 2; end
      end else if (kind == 6) begin
         m.a = 0;
         m.d = $urandom_range(1) ? 0 : rand_coef();
         m.c = rand_coef();
      end else if (kind == 7) begin
         m.a = 0; m.b = 0;
         m.c = $urandom_range(1) ? 0 : rand_coef();
         m.d = rand_coef();
      end else begin
         m.c = rand_coef(); m.d = rand_coef();
      end
      return m;
   endfunction

   row_type table_rows[$];

   function automatic void add_row(matrix_type m, bit fixed, decomp_type want);
      row_type r;
      r.m = m;
      r.fixed = fixed;
      r.want = want;
      table_rows.insert(table_rows.size(), r);
   endfunction

   function automatic decomp_type fixed_out(logic [31:0] sx, logic [31:0] sy,
                                            logic [15:0] rot, logic [31:0] px,
                                            logic [31:0] py, bit fell);
      decomp_type r;
      r = '{sx: sx, sy: sy, rot: rot, px: px, py: py, fell: fell};
      return r;
   endfunction

   initial begin
      matrix_type m;
      decomp_type want;
      // identity
      add_row('{32'd1024, 0, 0, 32'd1024, 0, 0}, 0, '0);
      // all zero column and zero matrix
      add_row('{0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000}, 1,
              fixed_out(0, 0, 0, MaxPos, MaxPos, 0));
      // zero column with c set: fallback
      add_row('{0, 0, 32'd5, 32'd7, 32'h8000_0000, 32'h7fff_ffff}, 1,
              fixed_out(OneQ16, OneQ16, 0, MinNeg, 32'h8000_0001, 1));
      // zero column, extreme d saturates
      add_row('{0, 0, 0, 32'h8000_0000, 0, 32'd1}, 1,
              fixed_out(0, MinNeg, 0, 0, 32'hffff_ffff, 0));
      add_row('{0, 0, 0, 32'h7fff_ffff, 32'hffff_ffff, 0}, 1,
              fixed_out(0, MaxPos, 0, 32'hffff_ffff, 0, 0));
      // zero cosine, d nonzero: fallback
      add_row('{0, 32'd1024, 32'hffff_fc00, 32'd3, 0, 0}, 1,
              fixed_out(OneQ16, OneQ16, 0, 0, 0, 1));
      // predictor rows: quarter turns, half turn, extremes, shear
      add_row('{0, 32'd1024, 32'hffff_fc00, 0, 0, 0}, 0, '0);
      add_row('{0, 32'hffff_fc00, 32'd1024, 0, 0, 0}, 0, '0);
      add_row('{32'hffff_fc00, 0, 0, 32'hffff_fc00, 0, 0}, 0, '0);
      add_row('{32'hffff_fc00, 32'd1, 32'd1, 32'hffff_fc00, 0, 0}, 0, '0);
      add_row('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0}, 0, '0);
      add_row('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0}, 0, '0);
      add_row('{32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0}, 0, '0);
      add_row('{32'd1, 0, 0, 32'h01ff_ffff, 0, 0}, 0, '0);
      add_row('{32'd1, 0, 0, 32'h0200_0000, 0, 0}, 0, '0);
      add_row('{32'd724, 32'd724, 32'hffff_fd2c, 32'd724, 0, 0}, 0, '0);
      add_row('{32'd1024, 32'd100, 32'd300, 32'd1024, 0, 0}, 0, '0);
      add_row('{32'd2048, 0, 32'd1, 32'd1024, 0, 0}, 0, '0);
      add_row('{32'd2048, 0, 32'd2, 32'd1024, 0, 0}, 0, '0);
      add_row('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         want = table_rows[i].fixed ? table_rows[i].want : decompose(table_rows[i].m);
         send(table_rows[i].m, want);
      end

      for (int n = 0; n < 1000; n++) begin
         // no idling on either side for one long stretch
         quiet_send = (n >= 300 && n < 450);
         quiet_recv = quiet_send;
         // drain once: sender holds off until every result is back
         if (n == 600) begin
            req_valid <= 1'b0;
            wait (pending.size() == 0);
            @(negedge clock);
         end
         m = rand_matrix();
         send(m, decompose(m));
      end
      req_valid <= 1'b0;

      wait (pending.size() == 0);
      repeat (Steps + 100) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : !idle_now(quiet_recv);
   end

   always @(posedge clock) begin
      decomp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{sx: rsp_scale_x, sy: rsp_scale_y, rot: rsp_rot_angle,
                 px: rsp_pos_x, py: rsp_pos_y, fell: rsp_fell_back};
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected item: %h", $realtime, got);
         end else begin
            want = pending.pop_front();
            if (got.sx !== want.sx) begin
               errors++;
               $display("%0t scale_x exp %h got %h", $realtime, want.sx, got.sx);
            end
            if (got.sy !== want.sy) begin
               errors++;
               $display("%0t scale_y exp %h got %h", $realtime, want.sy, got.sy);
            end
            if (got.rot !== want.rot) begin
               errors++;
               $display("%0t rot_angle exp %h got %h", $realtime, want.rot, got.rot);
            end
            if (got.px !== want.px) begin
               errors++;
               $display("%0t pos_x exp %h got %h", $realtime, want.px, got.px);
            end
            if (got.py !== want.py) begin
               errors++;
               $display("%0t pos_y exp %h got %h", $realtime, want.py, got.py);
            end
            if (got.fell !== want.fell) begin
               errors++;
               $display("%0t fell_back exp %b got %b", $realtime, want.fell, got.fell);
            end
         end
      end
   end

   // watchdog: ~1020 items, long pipeline, heavy idling, taken several times over
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

endmodule
